/* sv/scdt_pkg.sv */
// Shared types, codes and the commutation table for the six-step commutator.
// No dependencies; every other file imports this package.
package scdt_pkg;

    // command codes
    localparam logic [3:0] CMD_STEP    = 4'd0;
    localparam logic [3:0] CMD_LEG     = 4'd1;
    localparam logic [3:0] CMD_DUTY    = 4'd2;
    localparam logic [3:0] CMD_COAST   = 4'd3;
    localparam logic [3:0] CMD_BRAKE   = 4'd4;
    localparam logic [3:0] CMD_ENABLE  = 4'd5;
    localparam logic [3:0] CMD_DISABLE = 4'd6;
    localparam logic [3:0] CMD_ESTOP   = 4'd7;
    localparam logic [3:0] CMD_FAULT   = 4'd8;

    // leg modes
    localparam logic [1:0] MODE_FLOAT = 2'd0;
    localparam logic [1:0] MODE_LOW   = 2'd1;
    localparam logic [1:0] MODE_HIGH  = 2'd2;
    localparam logic [1:0] MODE_PWM   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_LEG    = 2'd0;
    localparam logic [1:0] KIND_WAIT   = 2'd1;
    localparam logic [1:0] KIND_PIN    = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_DEADTIME = 2'd0;
    localparam logic [1:0] REG_EN_POL   = 2'd1;
    localparam logic [1:0] REG_FLT_POL  = 2'd2;

    localparam logic [2:0] NUM_STEPS = 3'd6;
    localparam logic [1:0] NUM_LEGS  = 2'd3;
    localparam int         MAX_ITEMS = 8;

    typedef logic [2:0][1:0] leg_modes_t;

    typedef struct packed {
        logic [3:0]  command;
        logic [2:0]  step_index;
        logic [1:0]  phase_index;
        logic [1:0]  leg_mode_req;
        logic [15:0] duty_req;
        logic        fault_level;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] phase;
        logic [1:0] mode;
        logic [9:0] duty;
        logic       pin;
        logic       status;
        logic       faulted;
        logic [2:0] cur_step;
        logic [9:0] cur_duty;
        logic       enabled;
        logic       last;
    } item_t;

    typedef struct packed {
        item_t [MAX_ITEMS-1:0] items;
        logic [3:0]            count;
    } plan_t;

    typedef struct packed {
        leg_modes_t legs;
        logic [2:0] step;
        logic [9:0] duty;
        logic       enabled;
    } state_t;

    typedef struct packed {
        logic [15:0] deadtime_len;
        logic        enable_polarity_high;
        logic        fault_polarity_low;
    } cfg_t;

    // leg modes of each commutation step, leg U in element 0
    function automatic leg_modes_t step_modes(input logic [2:0] step);
        leg_modes_t m;
        case (step)
            3'd0: begin m[0] = MODE_PWM;   m[1] = MODE_LOW;   m[2] = MODE_FLOAT; end
            3'd1: begin m[0] = MODE_PWM;   m[1] = MODE_FLOAT; m[2] = MODE_LOW;   end
            3'd2: begin m[0] = MODE_FLOAT; m[1] = MODE_PWM;   m[2] = MODE_LOW;   end
            3'd3: begin m[0] = MODE_LOW;   m[1] = MODE_PWM;   m[2] = MODE_FLOAT; end
            3'd4: begin m[0] = MODE_LOW;   m[1] = MODE_FLOAT; m[2] = MODE_PWM;   end
            3'd5: begin m[0] = MODE_FLOAT; m[1] = MODE_LOW;   m[2] = MODE_PWM;   end
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic item_t mk_leg(input logic [1:0] phase, input logic [1:0] mode,
                                     input logic [9:0] duty);
        item_t it;
        it       = '0;
        it.kind  = KIND_LEG;
        it.phase = phase;
        it.mode  = mode;
        it.duty  = (mode == MODE_PWM) ? duty : 10'd0;
        return it;
    endfunction

endpackage

/* sv/scdt_if.sv */
// Handshake interfaces for the command, result and configuration channels.
// Depends on scdt_pkg.
interface scdt_cmd_if import scdt_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [3:0]  command;
    logic [2:0]  step_index;
    logic [1:0]  phase_index;
    logic [1:0]  leg_mode_req;
    logic [15:0] duty_req;
    logic        fault_level;

    modport source (output valid, command, step_index, phase_index, leg_mode_req,
                    duty_req, fault_level, input ready);
    modport sink   (input valid, command, step_index, phase_index, leg_mode_req,
                    duty_req, fault_level, output ready);
endinterface

interface scdt_res_if import scdt_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [1:0] out_phase;
    logic [1:0] out_mode;
    logic [9:0] out_duty;
    logic       pin_level;
    logic       status_code;
    logic       faulted;
    logic [2:0] cur_step;
    logic [9:0] cur_duty;
    logic       is_enabled;
    logic       last_item;

    modport source (output valid, result_kind, out_phase, out_mode, out_duty, pin_level,
                    status_code, faulted, cur_step, cur_duty, is_enabled, last_item,
                    input ready);
    modport sink   (input valid, result_kind, out_phase, out_mode, out_duty, pin_level,
                    status_code, faulted, cur_step, cur_duty, is_enabled, last_item,
                    output ready);
endinterface

interface scdt_cfg_if import scdt_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/six_step_commutator_deadtime_core.sv */
// Top level of the six-step commutator with software deadtime.
// Depends on scdt_pkg, scdt_if, scdt_planner and scdt_emitter.
//
// A command is taken into an input register, planned combinationally into a
// buffer of up to eight result transactions, and those leave one per cycle
// while the result channel is ready. A command gives one result for a
// status-only command, up to seven for a step change with deadtime and up to
// eight for a brake from three driven legs with deadtime. The next command is
// already held in the input register while the previous one drains, and is
// planned in the same cycle as the previous last transaction is taken, so
// commands follow with no gap. Configuration writes are always accepted.
module six_step_commutator_deadtime_core import scdt_pkg::*; #(
    parameter int DUTY_MAX = 1000
) (
    input  logic       clk,
    input  logic       rst_n,
    scdt_cmd_if.sink   cmd,
    scdt_res_if.source res,
    scdt_cfg_if.sink   cfg
);

    cmd_t   cmd_reg;
    logic   cmd_valid_reg;
    logic   cmd_valid_next;
    state_t state_reg;
    state_t state_next;
    cfg_t   cfg_reg;
    plan_t  plan;
    logic   free;
    logic   load;
    logic   cmd_fire;

    assign load      = cmd_valid_reg && free;
    assign cmd.ready = !cmd_valid_reg || free;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (cmd_fire)
            cmd_valid_next = 1'b1;
        else if (load)
            cmd_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= cmd_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cmd_reg.command      <= cmd.command;
            cmd_reg.step_index   <= cmd.step_index;
            cmd_reg.phase_index  <= cmd.phase_index;
            cmd_reg.leg_mode_req <= cmd.leg_mode_req;
            cmd_reg.duty_req     <= cmd.duty_req;
            cmd_reg.fault_level  <= cmd.fault_level;
        end
    end

    // commit state only when the plan enters the result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (load)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadtime_len         <= 16'd0;
            cfg_reg.enable_polarity_high <= 1'b1;
            cfg_reg.fault_polarity_low   <= 1'b1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_DEADTIME: cfg_reg.deadtime_len         <= cfg.data;
                REG_EN_POL:   cfg_reg.enable_polarity_high <= cfg.data[0];
                REG_FLT_POL:  cfg_reg.fault_polarity_low   <= cfg.data[0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    scdt_planner #(
        .DUTY_MAX (DUTY_MAX)
    ) u_planner (
        .cmd        (cmd_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .plan       (plan),
        .state_next (state_next)
    );

    scdt_emitter u_emitter (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .plan  (plan),
        .free  (free),
        .res   (res)
    );

    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && !load) |=> (cmd_valid_reg && $stable(cmd_reg)))
        else $error("pending command lost or overwritten");

    a_state_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(state_reg))
        else $error("leg state changed without a command");

    a_duty_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.duty <= 10'(DUTY_MAX))
        else $error("stored duty above limit");

endmodule

/* sv/scdt_planner.sv */
// Combinational planner: turns one registered command and the leg state into
// the full list of result transactions and the next state. Depends on scdt_pkg.
module scdt_planner import scdt_pkg::*; #(
    parameter int DUTY_MAX = 1000
) (
    input  cmd_t   cmd,
    input  state_t state,
    input  cfg_t   cfg,
    output plan_t  plan,
    output state_t state_next
);

    always_comb
    begin
        plan_t      p;
        state_t     ns;
        logic [3:0] n;
        leg_modes_t cur;
        leg_modes_t tgt;
        logic       chg;
        logic       do_apply;
        logic       do_float;
        logic       do_refresh;
        logic       do_pin;
        logic       pin_on;
        logic       err;
        logic       flt;
        logic [9:0] duty_c;
        logic [9:0] apply_duty;
        item_t      it;

        p          = '0;
        ns         = state;
        n          = 4'd0;
        cur        = state.legs;
        tgt        = state.legs;
        chg        = 1'b0;
        do_apply   = 1'b0;
        do_float   = 1'b0;
        do_refresh = 1'b0;
        do_pin     = 1'b0;
        pin_on     = 1'b0;
        err        = 1'b0;
        flt        = 1'b0;
        duty_c     = (cmd.duty_req > 16'(DUTY_MAX)) ? 10'(DUTY_MAX) : cmd.duty_req[9:0];
        apply_duty = duty_c;

        case (cmd.command)
            CMD_STEP:
            begin
                if (cmd.step_index >= NUM_STEPS)
                    err = 1'b1;
                else
                begin
                    do_apply = 1'b1;
                    tgt      = step_modes(cmd.step_index);
                    ns.step  = cmd.step_index;
                    ns.duty  = duty_c;
                end
            end
            CMD_LEG:
            begin
                if (cmd.phase_index >= NUM_LEGS)
                    err = 1'b1;
                else
                begin
                    do_apply = 1'b1;
                    if (cmd.leg_mode_req != MODE_PWM)
                        apply_duty = 10'd0;
                    tgt[cmd.phase_index] = cmd.leg_mode_req;
                end
            end
            CMD_DUTY:
            begin
                do_refresh = 1'b1;
                ns.duty    = duty_c;
            end
            CMD_COAST:
            begin
                do_float = 1'b1;
                ns.duty  = 10'd0;
            end
            CMD_BRAKE:
            begin
                do_apply   = 1'b1;
                tgt        = {MODE_LOW, MODE_LOW, MODE_LOW};
                apply_duty = 10'd0;
                ns.duty    = 10'd0;
            end
            CMD_ENABLE:
            begin
                do_pin     = 1'b1;
                pin_on     = 1'b1;
                ns.enabled = 1'b1;
            end
            CMD_DISABLE, CMD_ESTOP:
            begin
                do_float   = 1'b1;
                do_pin     = 1'b1;
                ns.enabled = 1'b0;
                ns.duty    = 10'd0;
            end
            CMD_FAULT:
                flt = cfg.fault_polarity_low ? !cmd.fault_level : cmd.fault_level;
            default:
                err = 1'b1;
        endcase

        if (do_float)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p.items[n[2:0]] = mk_leg(2'(i), MODE_FLOAT, 10'd0);
                n = n + 4'd1;
                cur[i] = MODE_FLOAT;
            end
        end

        if (do_apply)
        begin
            // float every driven leg that changes, wait if a deadtime is set, then drive the new modes
            for (int i = 0; i < 3; i++)
            begin
                if (cur[i] != tgt[i])
                begin
                    if (cur[i] != MODE_FLOAT)
                    begin
                        p.items[n[2:0]] = mk_leg(2'(i), MODE_FLOAT, 10'd0);
                        n = n + 4'd1;
                        cur[i] = MODE_FLOAT;
                    end
                    chg = 1'b1;
                end
            end
            if (chg && (cfg.deadtime_len != 16'd0))
            begin
                it      = '0;
                it.kind = KIND_WAIT;
                p.items[n[2:0]] = it;
                n = n + 4'd1;
            end
            for (int i = 0; i < 3; i++)
            begin
                if (!((cur[i] == tgt[i]) && (tgt[i] != MODE_PWM)))
                begin
                    p.items[n[2:0]] = mk_leg(2'(i), tgt[i], apply_duty);
                    n = n + 4'd1;
                    cur[i] = tgt[i];
                end
            end
        end

        if (do_refresh)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cur[i] == MODE_PWM)
                begin
                    p.items[n[2:0]] = mk_leg(2'(i), MODE_PWM, duty_c);
                    n = n + 4'd1;
                end
            end
        end

        if (do_pin)
        begin
            it      = '0;
            it.kind = KIND_PIN;
            it.pin  = cfg.enable_polarity_high ? pin_on : !pin_on;
            p.items[n[2:0]] = it;
            n = n + 4'd1;
        end

        ns.legs = cur;

        it          = '0;
        it.kind     = KIND_STATUS;
        it.status   = err;
        it.faulted  = flt;
        it.cur_step = ns.step;
        it.cur_duty = ns.duty;
        it.enabled  = ns.enabled;
        it.last     = 1'b1;
        p.items[n[2:0]] = it;
        n = n + 4'd1;

        p.count    = n;
        plan       = p;
        state_next = ns;
    end

endmodule

/* sv/scdt_emitter.sv */
// Result buffer: holds the planned transactions of one command and shifts them out
// one per cycle on the result channel while it is ready. Depends on scdt_pkg, scdt_if.
module scdt_emitter import scdt_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  plan_t          plan,
    output logic           free,
    scdt_res_if.source     res
);

    item_t [MAX_ITEMS-1:0] buf_reg;
    item_t [MAX_ITEMS-1:0] buf_next;
    logic [3:0]            count_reg;
    logic [3:0]            count_next;
    logic                  fire;
    item_t                 head;

    assign head = buf_reg[0];
    assign fire = res.valid && res.ready;
    assign free = (count_reg == 4'd0) || ((count_reg == 4'd1) && fire);

    always_comb
    begin
        buf_next   = buf_reg;
        count_next = count_reg;
        if (load)
        begin
            buf_next   = plan.items;
            count_next = plan.count;
        end
        else if (fire)
        begin
            // advance the queue by one transaction
            for (int i = 0; i < MAX_ITEMS - 1; i++)
                buf_next[i] = buf_reg[i+1];
            buf_next[MAX_ITEMS-1] = '0;
            count_next = count_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 4'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign res.valid       = (count_reg != 4'd0);
    assign res.result_kind = head.kind;
    assign res.out_phase   = head.phase;
    assign res.out_mode    = head.mode;
    assign res.out_duty    = head.duty;
    assign res.pin_level   = head.pin;
    assign res.status_code = head.status;
    assign res.faulted     = head.faulted;
    assign res.cur_step    = head.cur_step;
    assign res.cur_duty    = head.cur_duty;
    assign res.is_enabled  = head.enabled;
    assign res.last_item   = head.last;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("plan loaded while results still pending");

    a_last_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 4'd1) |-> head.last)
        else $error("final transaction of a command not marked last");

    a_count_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (count_reg == $past(plan.count)))
        else $error("buffer count does not match plan");

    a_plan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (plan.count != 4'd0))
        else $error("command planned without a status transaction");

endmodule
